// ----- hdl/mpm_pkg.sv -----
// ----------------------------------------------------------------------------
// mpm_pkg
// Shared field widths, command and register codes, and the per-cell flag word
// of the maze path merge generator.
// ----------------------------------------------------------------------------
package mpm_pkg;

	localparam int CMD_W     = 2;
	localparam int CELL_W    = 12;
	localparam int LABEL_W   = 12;
	localparam int GRID_W    = 7;
	localparam int WALLS_W   = 2;
	localparam int CFG_IDX_W = 1;
	// width x height fits here for any 7-bit pair
	localparam int PROD_W    = 14;

	typedef logic [CMD_W-1:0] cmd_t;

	// code 3 is handled like a read
	localparam cmd_t CMD_INIT    = 2'd0;
	localparam cmd_t CMD_CONNECT = 2'd1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_GRID_WIDTH  = 1'b0;
	localparam cfg_idx_t REG_GRID_HEIGHT = 1'b1;

	// direction bit doubles as the wall/border bit index
	localparam logic DIR_RIGHT = 1'b0;

	localparam logic [WALLS_W-1:0] WALLS_ALL = 2'b11;

	typedef struct packed {
		logic [WALLS_W-1:0] border;
		logic [WALLS_W-1:0] walls;
	} cell_flags_t;

endpackage

// ----- hdl/maze_path_merge_generator.sv -----
// ----------------------------------------------------------------------------
// maze_path_merge_generator
// Grid maze table with wall, border and path label per cell; init, connect
// (label merge) and read commands under one small sequencer.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result shows
// on the result ports for a single cycle with done high, and the receiver
// cannot stall it. Cell flags and labels sit in two RAMs with one write and
// one registered read port each, and a single compare unit walks them one
// cell per cycle. An init writes every cell below N, where N is grid_width
// times grid_height capped at MAX_CELLS, and then reads the cell; a bad
// cell is reported without a table read. A connect that joins ends with a
// relabel sweep through the label RAM over the cell count of the last
// init; a connect that fails both tries ends without one. done rises in
// the cycle that busy falls. The tables hold no valid state before the
// first init: every cell reads as bad until then. Configuration writes
// are always ready.
// ----------------------------------------------------------------------------
module maze_path_merge_generator #(
	parameter int MAX_CELLS = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  mpm_pkg::cmd_t                        command,
	input  logic [mpm_pkg::CELL_W-1:0]           cell_index,
	input  logic                                 first_direction,
	output logic                                 done,
	output logic                                 joined,
	output logic                                 joined_direction,
	output logic [mpm_pkg::WALLS_W-1:0]          cell_walls,
	output logic [mpm_pkg::LABEL_W-1:0]          cell_label,
	output logic                                 bad_cell,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  mpm_pkg::cfg_idx_t                    cfg_index,
	input  logic [mpm_pkg::GRID_W-1:0]           cfg_data
);

	import mpm_pkg::*;

	localparam int ADDR_W = $clog2(MAX_CELLS);
	localparam int LBL_W  = ADDR_W;
	localparam int CNT_W  = $clog2(MAX_CELLS + 1);
	localparam int CMP_W  = (CNT_W > PROD_W) ? CNT_W : PROD_W;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_INIT  = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_RDC   = 7'b0001000,
		S_TRY   = 7'b0010000,
		S_RDNB  = 7'b0100000,
		S_SCAN  = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [GRID_W-1:0]   grid_width_q;
	logic [GRID_W-1:0]   grid_height_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    i_q;
	logic [GRID_W-1:0]   col_q;
	logic [GRID_W-1:0]   row_q;
	logic                dir_q;
	logic                tries_q;
	logic                pend_q;
	logic                done_q;
	cmd_t                cmd_q;
	logic [CELL_W-1:0]   cell_q;
	cell_flags_t         flags_c_q;
	logic [LBL_W-1:0]    lab_c_q;
	logic [LBL_W-1:0]    old_q;
	logic [ADDR_W-1:0]   pidx_q;

	logic                joined_q;
	logic                jdir_q;
	logic [WALLS_W-1:0]  walls_q;
	logic [LABEL_W-1:0]  label_q;
	logic                bad_q;

	// RAM ports
	logic                flags_we;
	logic [ADDR_W-1:0]   flags_waddr;
	cell_flags_t         flags_wdata;
	cell_flags_t         flags_rdata;
	logic                lab_we;
	logic [ADDR_W-1:0]   lab_waddr;
	logic [LBL_W-1:0]    lab_wdata;
	logic [LBL_W-1:0]    lab_rdata;
	logic [ADDR_W-1:0]   raddr;

	logic [PROD_W-1:0]   prod;
	logic [CMP_W-1:0]    count_sat;
	logic [ADDR_W-1:0]   c_addr;
	logic [CMP_W-1:0]    nb;
	logic                bad_now;
	logic                try_ok;
	logic                same;
	logic                scan_go;
	logic [WALLS_W-1:0]  init_border;
	logic [WALLS_W-1:0]  walls_clr;
	logic                fin_en;
	logic                retry;
	logic                fin_joined;
	logic                fin_jdir;
	logic [WALLS_W-1:0]  fin_walls;
	logic [LABEL_W-1:0]  fin_label;
	logic                fin_bad;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign prod      = PROD_W'(grid_width_q) * PROD_W'(grid_height_q);
	assign count_sat = (CMP_W'(prod) > CMP_W'(MAX_CELLS)) ? CMP_W'(MAX_CELLS) : CMP_W'(prod);

	assign c_addr  = ADDR_W'(cell_q);
	assign bad_now = CMP_W'(cell_q) >= CMP_W'(count_q);
	assign nb      = CMP_W'(cell_q) +
	                 ((dir_q == DIR_RIGHT) ? CMP_W'(1) : CMP_W'(grid_width_q));
	// a neighbor past the table counts as a border
	assign try_ok  = !flags_c_q.border[dir_q] && (nb < CMP_W'(count_q));
	assign same    = (lab_rdata == lab_c_q);
	assign scan_go = CMP_W'(i_q) < CMP_W'(count_q);

	assign init_border[0] = (col_q == grid_width_q - GRID_W'(1));
	assign init_border[1] = (row_q == grid_height_q - GRID_W'(1));

	always_comb begin
		walls_clr        = flags_c_q.walls;
		walls_clr[dir_q] = 1'b0;
	end

	// RAM control
	always_comb begin
		flags_we           = 1'b0;
		flags_waddr        = c_addr;
		flags_wdata.border = flags_c_q.border;
		flags_wdata.walls  = walls_clr;
		lab_we             = 1'b0;
		lab_waddr          = pidx_q;
		lab_wdata          = lab_c_q;
		raddr              = c_addr;
		unique case (state_q)
			S_INIT: begin
				flags_we           = scan_go;
				flags_waddr        = i_q[ADDR_W-1:0];
				flags_wdata.border = init_border;
				flags_wdata.walls  = WALLS_ALL;
				lab_we             = scan_go;
				lab_waddr          = i_q[ADDR_W-1:0];
				lab_wdata          = LBL_W'(i_q);
			end
			S_TRY: begin
				raddr = ADDR_W'(nb);
			end
			S_RDNB: begin
				flags_we = !same;
			end
			S_SCAN: begin
				raddr  = i_q[ADDR_W-1:0];
				lab_we = pend_q && (lab_rdata == old_q);
			end
			default: begin
			end
		endcase
	end

	// finish and retry decisions
	always_comb begin
		fin_en     = 1'b0;
		retry      = 1'b0;
		fin_joined = 1'b0;
		fin_jdir   = 1'b0;
		fin_bad    = 1'b0;
		fin_walls  = flags_c_q.walls;
		fin_label  = LABEL_W'(lab_c_q);
		unique case (state_q)
			S_CHECK: begin
				fin_en    = bad_now;
				fin_bad   = 1'b1;
				fin_walls = '0;
				fin_label = '0;
			end
			S_RDC: begin
				fin_en    = (cmd_q != CMD_CONNECT);
				fin_walls = flags_rdata.walls;
				fin_label = LABEL_W'(lab_rdata);
			end
			S_TRY: begin
				fin_en = !try_ok && tries_q;
				retry  = !try_ok && !tries_q;
			end
			S_RDNB: begin
				fin_en = same && tries_q;
				retry  = same && !tries_q;
			end
			S_SCAN: begin
				fin_en     = !scan_go && !pend_q;
				fin_joined = 1'b1;
				fin_jdir   = dir_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			grid_width_q  <= GRID_W'(10);
			grid_height_q <= GRID_W'(10);
			count_q       <= '0;
			i_q           <= '0;
			dir_q         <= 1'b0;
			tries_q       <= 1'b0;
			pend_q        <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					REG_GRID_HEIGHT: grid_height_q <= cfg_data;
					default: begin
					end
				endcase
			end
			done_q <= fin_en;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						dir_q   <= first_direction;
						tries_q <= 1'b0;
						i_q     <= '0;
						if (command == CMD_INIT) begin
							count_q <= CNT_W'(count_sat);
							state_q <= S_INIT;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_INIT: begin
					if (scan_go) begin
						i_q <= i_q + CNT_W'(1);
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= bad_now ? S_IDLE : S_RDC;
				end
				S_RDC: begin
					state_q <= fin_en ? S_IDLE : S_TRY;
				end
				S_TRY: begin
					if (try_ok) begin
						state_q <= S_RDNB;
					end else if (retry) begin
						dir_q   <= ~dir_q;
						tries_q <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RDNB: begin
					if (!same) begin
						i_q     <= '0;
						pend_q  <= 1'b0;
						state_q <= S_SCAN;
					end else if (retry) begin
						dir_q   <= ~dir_q;
						tries_q <= 1'b1;
						state_q <= S_TRY;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					pend_q <= scan_go;
					if (scan_go) begin
						i_q <= i_q + CNT_W'(1);
					end
					if (fin_en) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q  <= command;
			cell_q <= cell_index;
			col_q  <= '0;
			row_q  <= '0;
		end
		if (state_q == S_INIT && scan_go) begin
			if (init_border[0]) begin
				col_q <= '0;
				row_q <= row_q + GRID_W'(1);
			end else begin
				col_q <= col_q + GRID_W'(1);
			end
		end
		if (state_q == S_RDC) begin
			flags_c_q <= flags_rdata;
			lab_c_q   <= lab_rdata;
		end
		if (state_q == S_RDNB && !same) begin
			flags_c_q.walls <= walls_clr;
			old_q           <= lab_rdata;
		end
		if (state_q == S_SCAN) begin
			pidx_q <= i_q[ADDR_W-1:0];
		end
		if (fin_en) begin
			joined_q <= fin_joined;
			jdir_q   <= fin_jdir;
			walls_q  <= fin_walls;
			label_q  <= fin_label;
			bad_q    <= fin_bad;
		end
	end

	mpm_ram #(
		.WIDTH ($bits(cell_flags_t)),
		.DEPTH (MAX_CELLS)
	) u_flags_ram (
		.clk   (clk),
		.we    (flags_we),
		.waddr (flags_waddr),
		.wdata (flags_wdata),
		.raddr (raddr),
		.rdata (flags_rdata)
	);

	mpm_ram #(
		.WIDTH (LBL_W),
		.DEPTH (MAX_CELLS)
	) u_label_ram (
		.clk   (clk),
		.we    (lab_we),
		.waddr (lab_waddr),
		.wdata (lab_wdata),
		.raddr (raddr),
		.rdata (lab_rdata)
	);

	assign done             = done_q;
	assign joined           = joined_q;
	assign joined_direction = jdir_q;
	assign cell_walls       = walls_q;
	assign cell_label       = label_q;
	assign bad_cell         = bad_q;

	// every accepted transaction makes the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not make the block busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction in flight");

	// a join always reports the removed wall as open
	a_join_wall: assert property (@(posedge clk) disable iff (!arst_n)
		done && joined |-> !cell_walls[joined_direction] && !bad_cell)
		else $error("joined result still shows the wall");

endmodule

// ----- hdl/mpm_ram.sv -----
// ----------------------------------------------------------------------------
// mpm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- tb/maze_path_merge_generator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_path_merge_generator_tb
// Self-checking bench for the maze path merge generator: a short table of
// directed commands, then random init/connect/read traffic over several grid
// sizes. Every command is run through a cell-table model in the bench, and
// each done strobe is checked in order against the predicted or typed cell result.
// ----------------------------------------------------------------------------
module maze_path_merge_generator_tb;
	import mpm_pkg::*;

	localparam int MAX_CELLS    = 4096;
	localparam int CLK_HALF     = 4;
	localparam int DRAIN_CYCLES = 4200;
	localparam int CYCLE_LIMIT  = 3000000;

	localparam cmd_t CMD_READ  = 2'd2;
	localparam cmd_t CMD_SPARE = 2'd3;

	typedef struct packed {
		logic               joined;
		logic               jdir;
		logic [WALLS_W-1:0] walls;
		logic [LABEL_W-1:0] label;
		logic               bad;
	} cell_result_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [CELL_W-1:0] cell_idx;
		logic              dir;
		logic              typed;
		cell_result_t      want;
	} directed_row_t;

	localparam cell_result_t RESULT_BAD = '{1'b0, 1'b0, 2'd0, 12'd0, 1'b1};
	localparam cell_result_t RESULT_ANY = '0;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	cmd_t                 command;
	logic [CELL_W-1:0]    cell_index;
	logic                 first_direction;
	logic                 done;
	logic                 joined;
	logic                 joined_direction;
	logic [WALLS_W-1:0]   cell_walls;
	logic [LABEL_W-1:0]   cell_label;
	logic                 bad_cell;
	logic                 cfg_valid;
	logic                 cfg_ready;
	cfg_idx_t             cfg_index;
	logic [GRID_W-1:0]    cfg_data;

	// bench copy of the cell table
	logic [WALLS_W-1:0] wall_mem   [MAX_CELLS];
	logic [WALLS_W-1:0] border_mem [MAX_CELLS];
	logic [LABEL_W-1:0] label_mem  [MAX_CELLS];
	int unsigned        n_cells;
	int unsigned        width_reg;
	int unsigned        height_reg;

	cell_result_t  pending_results [$];
	directed_row_t directed_rows [22];
	int            error_count;
	int            cycle_count;

	maze_path_merge_generator #(
		.MAX_CELLS(MAX_CELLS)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.command          (command),
		.cell_index       (cell_index),
		.first_direction  (first_direction),
		.done             (done),
		.joined           (joined),
		.joined_direction (joined_direction),
		.cell_walls       (cell_walls),
		.cell_label       (cell_label),
		.bad_cell         (bad_cell),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	// one merge attempt from cell c toward right (bottom=0) or bottom neighbor
	function automatic bit try_merge(int unsigned c, logic bottom);
		logic [WALLS_W-1:0] mask;
		int unsigned        nb;
		logic [LABEL_W-1:0] old_l;
		logic [LABEL_W-1:0] new_l;
		mask = bottom ? 2'b10 : 2'b01;
		nb   = c + (bottom ? width_reg : 1);
		if ((border_mem[c] & mask) != 0)
			return 1'b0;
		if (nb >= n_cells)
			return 1'b0;
		if (label_mem[nb] == label_mem[c])
			return 1'b0;
		wall_mem[c] = wall_mem[c] & ~mask;
		old_l = label_mem[nb];
		new_l = label_mem[c];
		for (int unsigned i = 0; i < n_cells; i++)
			if (label_mem[i] == old_l)
				label_mem[i] = new_l;
		return 1'b1;
	endfunction

	task automatic predict_cell_step(input cmd_t c, input logic [CELL_W-1:0] idx,
			input logic d, output cell_result_t r);
		int unsigned n;
		r = '0;
		if (c == CMD_INIT) begin
			n = width_reg * height_reg;
			if (n > MAX_CELLS)
				n = MAX_CELLS;
			n_cells = n;
			for (int unsigned i = 0; i < n; i++) begin
				border_mem[i] = {(i / width_reg) == height_reg - 1,
						(i % width_reg) == width_reg - 1};
				wall_mem[i]   = WALLS_ALL;
				label_mem[i]  = i[LABEL_W-1:0];
			end
		end
		if (32'(idx) >= n_cells) begin
			r.bad = 1'b1;
			return;
		end
		if (c == CMD_CONNECT) begin
			if (try_merge(32'(idx), d)) begin
				r.joined = 1'b1;
				r.jdir   = d;
			end else if (try_merge(32'(idx), !d)) begin
				r.joined = 1'b1;
				r.jdir   = !d;
			end
		end
		r.walls = wall_mem[idx];
		r.label = label_mem[idx];
	endtask

	// start is left high after a transaction; the next call lowers it or
	// presents the next command at its first falling edge
	task automatic send_item(cmd_t c, logic [CELL_W-1:0] idx, logic d, logic typed,
			cell_result_t want, int gap);
		cell_result_t pred;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start           <= 1'b1;
		command         <= c;
		cell_index      <= idx;
		first_direction <= d;
		do @(posedge clk); while (busy);
		predict_cell_step(c, idx, d, pred);
		pending_results.push_back(typed ? want : pred);
	endtask

	task automatic settle_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [GRID_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_GRID_WIDTH)
			width_reg = 32'(val);
		else
			height_reg = 32'(val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure_grid(int w, int h);
		settle_idle();
		write_reg(REG_GRID_WIDTH, w[GRID_W-1:0]);
		write_reg(REG_GRID_HEIGHT, h[GRID_W-1:0]);
	endtask

	// mostly well-formed traffic: init first when init_first is set, then connects on live cells,
	// some reads and a little noise across the whole index range
	task automatic run_random(int items, bit idle_on, bit init_first, int pause_at);
		int                pick;
		int                gap;
		cmd_t              c;
		logic [CELL_W-1:0] idx;
		logic              d;
		for (int k = 0; k < items; k++) begin
			pick = $urandom_range(0, 99);
			d    = 1'($urandom_range(0, 1));
			idx  = (n_cells > 0) ? CELL_W'($urandom_range(0, n_cells - 1)) :
					CELL_W'($urandom);
			if ((k == 0 && init_first) || pick < 6) begin
				c = CMD_INIT;
				if ($urandom_range(0, 3) == 0)
					idx = CELL_W'($urandom);
			end else if (pick < 76) begin
				c = CMD_CONNECT;
			end else if (pick < 88) begin
				c = $urandom_range(0, 1) ? CMD_READ : CMD_SPARE;
			end else begin
				c   = cmd_t'($urandom_range(0, 3));
				idx = CELL_W'($urandom);
			end
			if (k == pause_at)
				settle_idle();
			gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
			send_item(c, idx, d, 1'b0, RESULT_ANY, gap);
		end
	endtask

	always @(posedge clk) begin
		cell_result_t got;
		cell_result_t want;
		if (arst_n && done) begin
			got = '{joined, joined_direction, cell_walls, cell_label, bad_cell};
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, label", got.label, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.joined !== want.joined)
					report_mismatch("joined", got.joined, want.joined);
				if (got.jdir !== want.jdir)
					report_mismatch("joined_direction", got.jdir, want.jdir);
				if (got.walls !== want.walls)
					report_mismatch("cell_walls", got.walls, want.walls);
				if (got.label !== want.label)
					report_mismatch("cell_label", got.label, want.label);
				if (got.bad !== want.bad)
					report_mismatch("bad_cell", got.bad, want.bad);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		command         = CMD_INIT;
		cell_index      = '0;
		first_direction = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = REG_GRID_WIDTH;
		cfg_data        = '0;
		error_count     = 0;
		cycle_count     = 0;
		n_cells         = 0;
		width_reg       = 10;
		height_reg      = 10;

		// default 10 x 10 grid; typed rows are bad cells and fresh init values
		directed_rows = '{
			'{CMD_READ,    12'd0,    1'b0, 1'b1, RESULT_BAD},
			'{CMD_CONNECT, 12'd5,    1'b1, 1'b1, RESULT_BAD},
			'{CMD_SPARE,   12'd4095, 1'b0, 1'b1, RESULT_BAD},
			'{CMD_INIT,    12'd0,    1'b0, 1'b1, '{1'b0, 1'b0, 2'd3, 12'd0, 1'b0}},
			'{CMD_INIT,    12'd99,   1'b1, 1'b1, '{1'b0, 1'b0, 2'd3, 12'd99, 1'b0}},
			'{CMD_INIT,    12'd100,  1'b0, 1'b1, RESULT_BAD},
			'{CMD_READ,    12'd4095, 1'b1, 1'b1, RESULT_BAD},
			'{CMD_CONNECT, 12'd0,    1'b0, 1'b0, RESULT_ANY},
			'{CMD_CONNECT, 12'd0,    1'b1, 1'b0, RESULT_ANY},
			'{CMD_CONNECT, 12'd0,    1'b0, 1'b0, RESULT_ANY},
			'{CMD_CONNECT, 12'd9,    1'b0, 1'b0, RESULT_ANY},
			'{CMD_CONNECT, 12'd99,   1'b1, 1'b0, RESULT_ANY},
			'{CMD_CONNECT, 12'd90,   1'b1, 1'b0, RESULT_ANY},
			'{CMD_CONNECT, 12'd89,   1'b1, 1'b0, RESULT_ANY},
			'{CMD_CONNECT, 12'd98,   1'b0, 1'b0, RESULT_ANY},
			'{CMD_READ,    12'd99,   1'b0, 1'b0, RESULT_ANY},
			'{CMD_READ,    12'd1,    1'b1, 1'b0, RESULT_ANY},
			'{CMD_SPARE,   12'd10,   1'b1, 1'b0, RESULT_ANY},
			'{CMD_CONNECT, 12'd1,    1'b1, 1'b0, RESULT_ANY},
			'{CMD_CONNECT, 12'd11,   1'b0, 1'b0, RESULT_ANY},
			'{CMD_CONNECT, 12'd4095, 1'b1, 1'b1, RESULT_BAD},
			'{CMD_READ,    12'd0,    1'b0, 1'b0, RESULT_ANY}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r])
			send_item(directed_rows[r].cmd, directed_rows[r].cell_idx, directed_rows[r].dir,
					directed_rows[r].typed, directed_rows[r].want,
					($urandom_range(0, 2) == 0) ? $urandom_range(1, 19) : 0);

		configure_grid(2, 2);
		run_random(10, 1'b1, 1'b1, -1);
		configure_grid(64, 2);
		run_random(14, 1'b1, 1'b1, -1);
		configure_grid(2, 64);
		run_random(14, 1'b1, 1'b1, -1);
		configure_grid(5, 40);
		run_random(20, 1'b1, 1'b1, -1);
		configure_grid(16, 16);
		run_random(24, 1'b1, 1'b1, 12);

		// new width without a fresh init: old borders, new bottom stride
		settle_idle();
		write_reg(REG_GRID_WIDTH, 7'd12);
		run_random(10, 1'b1, 1'b0, -1);

		configure_grid(64, 64);
		run_random(12, 1'b1, 1'b1, -1);
		configure_grid(9, 11);
		run_random(30, 1'b0, 1'b1, -1);

		settle_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
